// File: rtl/core/pose_velocity_gate_unit_assert.svh
// assertion macros for the pose velocity gate
// expects signals named clock and reset in the module that uses them
`ifndef POSE_VELOCITY_GATE_UNIT_ASSERT_SVH
`define POSE_VELOCITY_GATE_UNIT_ASSERT_SVH

// same-cycle implication
`define PVG_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pvg: assertion failed");

// next-cycle implication
`define PVG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pvg: assertion failed");

`endif

// File: rtl/core/pvg_pkg.sv
// shared types and constants of the pose velocity gate
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pvg_pkg;

   localparam int SPEED_W    = 8;
   localparam int JUMP_W     = 24;
   localparam int TIMEOUT_W  = 24;
   localparam int TIME_W     = 32;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_SPEED      = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_JUMP       = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ACCEPT_TIMEOUT = 2'd2;

   localparam logic [SPEED_W-1:0]   MAX_SPEED_RST      = 8'd5;
   localparam logic [JUMP_W-1:0]    MIN_JUMP_RST       = 24'd50000;
   localparam logic [TIMEOUT_W-1:0] ACCEPT_TIMEOUT_RST = 24'd500000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQX,
      ST_SQY,
      ST_SQZ,
      ST_LIM,
      ST_MJ2,
      ST_LIM2,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MUL_SQX,
      MUL_SQY,
      MUL_SQZ,
      MUL_LIM,
      MUL_MJ2,
      MUL_LIM2
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      mul_op_type mul_op;
      logic       acc_first;
      logic       acc_add;
      logic       lim_load;
      logic       mj2_load;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic check;
   } status_type;

   typedef struct packed {
      logic [SPEED_W-1:0]   max_speed;
      logic [JUMP_W-1:0]    min_jump;
      logic [TIMEOUT_W-1:0] accept_timeout;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/core/pose_velocity_gate_unit.sv
// top level of the pose velocity gate: velocity-gated outlier rejection
// depends on pvg_pkg, pvg_csr, pvg_dp, pvg_ctrl
//
//  port group  direction  handshake            payload
//  req_        in         req_valid/req_ready  pos_x, pos_y, pos_z, timestamp
//  rsp_        out        rsp_valid/rsp_ready  accepted
//  csr_        in         csr_wr_en            csr_index, csr_wr_data
//
// one item at a time; the shared 32x32 multiplier sets the pace
// after accept: SQX, SQY, SQZ, LIM, MJ2, LIM2, DONE if the speed gate applies,
// SQX and DONE if it does not (no reference, zero elapsed time or timeout reached)
// a waiting result holds the item in its last cycle until rsp_ready frees the slot
// reset clears the reference flag and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module pose_velocity_gate_unit #(
   parameter int POSITION_BITS = 28
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [POSITION_BITS-1:0]       req_pos_x,
   input  wire logic [POSITION_BITS-1:0]       req_pos_y,
   input  wire logic [POSITION_BITS-1:0]       req_pos_z,
   input  wire logic [pvg_pkg::TIME_W-1:0]     req_timestamp,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_accepted,
   input  wire logic                           csr_wr_en,
   input  wire logic [pvg_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [pvg_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   pvg_pkg::cfg_type    cfg;
   pvg_pkg::cmd_type    cmd;
   pvg_pkg::status_type status;

   pvg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   pvg_dp #(
      .POSITION_BITS (POSITION_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .cfg           (cfg),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_timestamp (req_timestamp),
      .rsp_accepted  (rsp_accepted)
   );

   pvg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// File: rtl/core/pvg_csr.sv
// configuration registers of the pose velocity gate
// depends on pvg_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvg_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_wr_en,
   input  wire logic [pvg_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [pvg_pkg::CSR_DATA_W-1:0]   csr_wr_data,
   output pvg_pkg::cfg_type                      cfg
);

   pvg_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pvg_pkg::CSR_MAX_SPEED: begin
               cfg_in.max_speed = csr_wr_data[pvg_pkg::SPEED_W-1:0];
            end
            pvg_pkg::CSR_MIN_JUMP: begin
               cfg_in.min_jump = csr_wr_data[pvg_pkg::JUMP_W-1:0];
            end
            pvg_pkg::CSR_ACCEPT_TIMEOUT: begin
               cfg_in.accept_timeout = csr_wr_data[pvg_pkg::TIMEOUT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_speed      <= pvg_pkg::MAX_SPEED_RST;
         cfg_ff.min_jump       <= pvg_pkg::MIN_JUMP_RST;
         cfg_ff.accept_timeout <= pvg_pkg::ACCEPT_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/core/pvg_dp.sv
// datapath of the pose velocity gate: reference pose, shared multiplier, compare
// depends on pvg_pkg
`timescale 1ns / 1ps
`default_nettype none

module pvg_dp #(
   parameter int POSITION_BITS = 28
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire pvg_pkg::cmd_type               cmd,
   output pvg_pkg::status_type                 status,
   input  wire pvg_pkg::cfg_type               cfg,
   input  wire logic [POSITION_BITS-1:0]       req_pos_x,
   input  wire logic [POSITION_BITS-1:0]       req_pos_y,
   input  wire logic [POSITION_BITS-1:0]       req_pos_z,
   input  wire logic [pvg_pkg::TIME_W-1:0]     req_timestamp,
   output logic                                rsp_accepted
);

   localparam int P    = POSITION_BITS;
   localparam int D2_W = 2 * POSITION_BITS + 2;
   localparam int MJ_W = 2 * pvg_pkg::JUMP_W;

   // reference pose
   logic [P-1:0]               ref_x_ff, ref_y_ff, ref_z_ff;
   logic [pvg_pkg::TIME_W-1:0] ref_time_ff;
   logic                       ref_valid_ff, ref_valid_in;

   // item under work
   logic [P-1:0]                  new_x_ff, new_y_ff, new_z_ff;
   logic [pvg_pkg::TIME_W-1:0]    new_time_ff;
   logic [P-1:0]                  mag_x_ff, mag_y_ff, mag_z_ff;
   logic [P-1:0]                  mag_x_in, mag_y_in, mag_z_in;
   logic [pvg_pkg::TIMEOUT_W-1:0] dt_ff;
   logic                          check_ff, check_in;

   logic [pvg_pkg::TIME_W-1:0] dt;
   logic [P:0]                 dx, dy, dz, ax, ay, az;

   logic [pvg_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [pvg_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic [D2_W-1:0]            d2_ff;
   logic [pvg_pkg::MUL_W-1:0]  lim_ff;
   logic [MJ_W-1:0]            mj2_ff;

   logic [pvg_pkg::PROD_W-1:0] d2_ext;
   logic                       reject;
   logic                       rsp_accepted_ff;

   // differences in P+1 bits, then magnitude, which always fits in P bits
   always_comb begin
      dx = {req_pos_x[P-1], req_pos_x} - {ref_x_ff[P-1], ref_x_ff};
      dy = {req_pos_y[P-1], req_pos_y} - {ref_y_ff[P-1], ref_y_ff};
      dz = {req_pos_z[P-1], req_pos_z} - {ref_z_ff[P-1], ref_z_ff};
      ax = dx[P] ? (~dx + 1'b1) : dx;
      ay = dy[P] ? (~dy + 1'b1) : dy;
      az = dz[P] ? (~dz + 1'b1) : dz;
      mag_x_in = ax[P-1:0];
      mag_y_in = ay[P-1:0];
      mag_z_in = az[P-1:0];
      dt = req_timestamp - ref_time_ff;
      check_in = ref_valid_ff && (dt != '0) &&
                 (dt < pvg_pkg::TIME_W'(cfg.accept_timeout));
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         new_x_ff    <= req_pos_x;
         new_y_ff    <= req_pos_y;
         new_z_ff    <= req_pos_z;
         new_time_ff <= req_timestamp;
         mag_x_ff    <= mag_x_in;
         mag_y_ff    <= mag_y_in;
         mag_z_ff    <= mag_z_in;
         dt_ff       <= dt[pvg_pkg::TIMEOUT_W-1:0];
         check_ff    <= check_in;
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_op)
         pvg_pkg::MUL_SQX: begin
            mul_a = pvg_pkg::MUL_W'(mag_x_ff);
            mul_b = pvg_pkg::MUL_W'(mag_x_ff);
         end
         pvg_pkg::MUL_SQY: begin
            mul_a = pvg_pkg::MUL_W'(mag_y_ff);
            mul_b = pvg_pkg::MUL_W'(mag_y_ff);
         end
         pvg_pkg::MUL_SQZ: begin
            mul_a = pvg_pkg::MUL_W'(mag_z_ff);
            mul_b = pvg_pkg::MUL_W'(mag_z_ff);
         end
         pvg_pkg::MUL_LIM: begin
            mul_a = pvg_pkg::MUL_W'(cfg.max_speed);
            mul_b = pvg_pkg::MUL_W'(dt_ff);
         end
         pvg_pkg::MUL_MJ2: begin
            mul_a = pvg_pkg::MUL_W'(cfg.min_jump);
            mul_b = pvg_pkg::MUL_W'(cfg.min_jump);
         end
         pvg_pkg::MUL_LIM2: begin
            mul_a = lim_ff;
            mul_b = lim_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = pvg_pkg::PROD_W'(mul_a) * pvg_pkg::PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_first) begin
         d2_ff <= prod_ff[D2_W-1:0];
      end else if (cmd.acc_add) begin
         d2_ff <= d2_ff + prod_ff[D2_W-1:0];
      end
      if (cmd.lim_load) begin
         lim_ff <= prod_ff[pvg_pkg::MUL_W-1:0];
      end
      if (cmd.mj2_load) begin
         mj2_ff <= prod_ff[MJ_W-1:0];
      end
   end

   // prod_ff holds the squared speed limit when finish is issued after the speed gate sequence
   always_comb begin
      d2_ext = pvg_pkg::PROD_W'(d2_ff);
      reject = check_ff && (d2_ext > prod_ff) && (d2_ext > pvg_pkg::PROD_W'(mj2_ff));
      ref_valid_in = ref_valid_ff;
      if (cmd.finish && !reject) begin
         ref_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_accepted_ff <= !reject;
         if (!reject) begin
            ref_x_ff    <= new_x_ff;
            ref_y_ff    <= new_y_ff;
            ref_z_ff    <= new_z_ff;
            ref_time_ff <= new_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_valid_ff <= 1'b0;
      end else begin
         ref_valid_ff <= ref_valid_in;
      end
   end

   assign status.check = check_ff;
   assign rsp_accepted = rsp_accepted_ff;

endmodule

`default_nettype wire

// File: rtl/core/pvg_ctrl.sv
// sequencer of the pose velocity gate: handshakes and datapath commands
// depends on pvg_pkg and pose_velocity_gate_unit_assert.svh
`timescale 1ns / 1ps
`default_nettype none

`include "pose_velocity_gate_unit_assert.svh"

module pvg_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output pvg_pkg::cmd_type          cmd,
   input  wire pvg_pkg::status_type  status
);

   pvg_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pvg_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = pvg_pkg::ST_SQX;
            end
         end
         pvg_pkg::ST_SQX: begin
            // no gating needed: go straight to the decision; else go on with SQY
            state_in = status.check ? pvg_pkg::ST_SQY : pvg_pkg::ST_DONE;
         end
         pvg_pkg::ST_SQY: begin
            state_in = pvg_pkg::ST_SQZ;
         end
         pvg_pkg::ST_SQZ: begin
            state_in = pvg_pkg::ST_LIM;
         end
         pvg_pkg::ST_LIM: begin
            state_in = pvg_pkg::ST_MJ2;
         end
         pvg_pkg::ST_MJ2: begin
            state_in = pvg_pkg::ST_LIM2;
         end
         pvg_pkg::ST_LIM2: begin
            state_in = pvg_pkg::ST_DONE;
         end
         pvg_pkg::ST_DONE: begin
            if (slot_free) begin
               state_in = pvg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pvg_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      cmd.mul_op = pvg_pkg::MUL_SQX;
      req_ready = 1'b0;
      case (state_ff)
         pvg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         pvg_pkg::ST_SQX: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_SQX;
         end
         pvg_pkg::ST_SQY: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_SQY;
            cmd.acc_first = 1'b1;
         end
         pvg_pkg::ST_SQZ: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_SQZ;
            cmd.acc_add = 1'b1;
         end
         pvg_pkg::ST_LIM: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_LIM;
            cmd.acc_add = 1'b1;
         end
         pvg_pkg::ST_MJ2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_MJ2;
            cmd.lim_load = 1'b1;
         end
         pvg_pkg::ST_LIM2: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = pvg_pkg::MUL_LIM2;
            cmd.mj2_load = 1'b1;
         end
         pvg_pkg::ST_DONE: begin
            cmd.finish = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pvg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PVG_ASSERT_IMPL(a_finish_slot, cmd.finish, !rsp_valid_ff || rsp_ready)
   `PVG_ASSERT_NEXT(a_finish_rsp, cmd.finish, rsp_valid_ff)
   `PVG_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.mul_en, cmd.finish}))
   `PVG_ASSERT_NEXT(a_load_seq, cmd.load, state_ff == pvg_pkg::ST_SQX)

endmodule

`default_nettype wire

// File: verif/pose_velocity_gate_unit_tb.sv
// self-checking testbench for pose_velocity_gate_unit: directed and random pose items
// with a scoreboard class that predicts every accept or reject verdict
// depends on pvg_pkg and the pose_velocity_gate_unit rtl
`timescale 1ns / 1ps

module pose_velocity_gate_unit_tb;

   localparam int POS_W           = 28;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 20;
   localparam int PHASE_ITEMS     = 80;

   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

   logic clock;
   logic reset         = 1'b1;
   logic req_valid     = 1'b0;
   logic req_ready;
   logic [POS_W-1:0]           req_pos_x     = '0;
   logic [POS_W-1:0]           req_pos_y     = '0;
   logic [POS_W-1:0]           req_pos_z     = '0;
   logic [pvg_pkg::TIME_W-1:0] req_timestamp = '0;
   logic rsp_valid;
   logic rsp_ready     = 1'b0;
   logic rsp_accepted;
   logic                           csr_wr_en   = 1'b0;
   logic [pvg_pkg::CSR_ADDR_W-1:0] csr_index   = '0;
   logic [pvg_pkg::CSR_DATA_W-1:0] csr_wr_data = '0;

   bit hold_off_request = 1'b0;
   int cycle_count      = 0;

   pose_velocity_gate_unit #(.POSITION_BITS(POS_W)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pos_x    (req_pos_x),
      .req_pos_y    (req_pos_y),
      .req_pos_z    (req_pos_z),
      .req_timestamp(req_timestamp),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_accepted (rsp_accepted),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data)
   );

   class pose_gate_scoreboard;
      logic [pvg_pkg::SPEED_W-1:0]   max_speed;
      logic [pvg_pkg::JUMP_W-1:0]    min_jump;
      logic [pvg_pkg::TIMEOUT_W-1:0] accept_timeout;
      logic signed [POS_W-1:0]       anchor_x;
      logic signed [POS_W-1:0]       anchor_y;
      logic signed [POS_W-1:0]       anchor_z;
      logic [pvg_pkg::TIME_W-1:0]    anchor_time;
      bit                            anchor_valid;
      bit                            expected_verdicts[$];
      int                            error_count;

      function new();
         max_speed      = pvg_pkg::MAX_SPEED_RST;
         min_jump       = pvg_pkg::MIN_JUMP_RST;
         accept_timeout = pvg_pkg::ACCEPT_TIMEOUT_RST;
         anchor_x       = '0;
         anchor_y       = '0;
         anchor_z       = '0;
         anchor_time    = '0;
         anchor_valid   = 1'b0;
         error_count    = 0;
      endfunction

      function void set_reg(logic [pvg_pkg::CSR_ADDR_W-1:0] index,
                            logic [pvg_pkg::CSR_DATA_W-1:0] data);
         case (index)
            pvg_pkg::CSR_MAX_SPEED:      max_speed      = data[pvg_pkg::SPEED_W-1:0];
            pvg_pkg::CSR_MIN_JUMP:       min_jump       = data[pvg_pkg::JUMP_W-1:0];
            pvg_pkg::CSR_ACCEPT_TIMEOUT: accept_timeout = data[pvg_pkg::TIMEOUT_W-1:0];
            default: ;
         endcase
      endfunction

      // verdict for one pose; an accepted pose replaces the anchor
      function bit gate_verdict(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                                logic signed [POS_W-1:0] z, logic [pvg_pkg::TIME_W-1:0] t);
         logic [pvg_pkg::TIME_W-1:0] elapsed;
         longint                     dx, dy, dz;
         logic [63:0]                dist2, lim, lim2, jump2;
         bit                         reject;
         elapsed = t - anchor_time;
         reject  = 1'b0;
         if (anchor_valid && elapsed != 0 &&
             elapsed < pvg_pkg::TIME_W'(accept_timeout)) begin
            dx = longint'(x) - longint'(anchor_x);
            dy = longint'(y) - longint'(anchor_y);
            dz = longint'(z) - longint'(anchor_z);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dz < 0) dz = -dz;
            dist2  = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
            lim    = 64'(max_speed) * 64'(elapsed);
            lim2   = lim * lim;
            jump2  = 64'(min_jump) * 64'(min_jump);
            reject = (dist2 > lim2) && (dist2 > jump2);
         end
         if (!reject) begin
            anchor_x     = x;
            anchor_y     = y;
            anchor_z     = z;
            anchor_time  = t;
            anchor_valid = 1'b1;
         end
         return !reject;
      endfunction

      function void note_pose(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                              logic signed [POS_W-1:0] z, logic [pvg_pkg::TIME_W-1:0] t);
         expected_verdicts.push_back(gate_verdict(x, y, z, t));
      endfunction

      function void check_verdict(logic actual);
         bit want;
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result item, expected none actual %0b", $time, actual);
            error_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (actual !== want) begin
               $display("%0t: accepted mismatch, expected %0b actual %0b", $time, want, actual);
               error_count++;
            end
         end
      endfunction

      function int pending_count();
         return expected_verdicts.size();
      endfunction
   endclass

   pose_gate_scoreboard sb = new();

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_verdict(rsp_accepted);
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 15);
      return $urandom_range(30, 120);
   endfunction

   initial begin : rsp_side
      int stall;
      int burst;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = HOLD_OFF_CYCLES;
         end else begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
         repeat (burst) @(posedge clock);
      end
   end

   // returns at the edge where the item is taken; valid stays high for a back-to-back item
   task automatic send_pose(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                            input logic signed [POS_W-1:0] z,
                            input logic [pvg_pkg::TIME_W-1:0] t);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_pos_x     <= x;
      req_pos_y     <= y;
      req_pos_z     <= z;
      req_timestamp <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_pose(x, y, z, t);
   endtask

   task automatic drain_results();
      do @(posedge clock); while (sb.pending_count() != 0);
   endtask

   task automatic write_settings(input logic [pvg_pkg::CSR_DATA_W-1:0] speed,
                                 input logic [pvg_pkg::CSR_DATA_W-1:0] jump,
                                 input logic [pvg_pkg::CSR_DATA_W-1:0] timeout);
      csr_wr_en   <= 1'b1;
      csr_index   <= pvg_pkg::CSR_MAX_SPEED;
      csr_wr_data <= speed;
      @(posedge clock);
      sb.set_reg(pvg_pkg::CSR_MAX_SPEED, speed);
      csr_index   <= pvg_pkg::CSR_MIN_JUMP;
      csr_wr_data <= jump;
      @(posedge clock);
      sb.set_reg(pvg_pkg::CSR_MIN_JUMP, jump);
      csr_index   <= pvg_pkg::CSR_ACCEPT_TIMEOUT;
      csr_wr_data <= timeout;
      @(posedge clock);
      sb.set_reg(pvg_pkg::CSR_ACCEPT_TIMEOUT, timeout);
      csr_wr_en   <= 1'b0;
   endtask

   // next track pose near the current anchor, with boundary steps, noise and random poses
   task automatic make_track_pose(output logic signed [POS_W-1:0] x,
                                  output logic signed [POS_W-1:0] y,
                                  output logic signed [POS_W-1:0] z,
                                  output logic [pvg_pkg::TIME_W-1:0] t);
      int unsigned                mode;
      int unsigned                pick;
      int unsigned                axis;
      logic [pvg_pkg::TIME_W-1:0] elapsed;
      longint                     lim, bound, edge_dist, dx, dy, dz;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       elapsed = '0;
         1:       elapsed = pvg_pkg::TIME_W'(sb.accept_timeout) - 1 + $urandom_range(0, 2);
         2:       elapsed = $urandom;
         3:       elapsed = -pvg_pkg::TIME_W'($urandom_range(1, 1000));
         default: elapsed = $urandom_range(1, 2000);
      endcase
      t     = sb.anchor_time + elapsed;
      lim   = (elapsed < 32'h0100_0000) ? longint'(sb.max_speed) * longint'(elapsed) : 0;
      bound = (lim > longint'(sb.min_jump)) ? lim : longint'(sb.min_jump);
      if (bound > (64'd1 << 26)) bound = 64'd1 << 26;
      if (bound < 2) bound = 2;
      dx = 0;
      dy = 0;
      dz = 0;
      mode = $urandom_range(0, 99);
      if (mode < 15) begin
         x = POS_W'($urandom);
         y = POS_W'($urandom);
         z = POS_W'($urandom);
         t = $urandom;
      end else begin
         if (mode < 45) begin
            // step along one axis right at the speed or the jump boundary
            edge_dist = $urandom_range(0, 1) ? lim : longint'(sb.min_jump);
            if (edge_dist > (64'd1 << 26)) edge_dist = 64'd1 << 26;
            edge_dist = edge_dist + $urandom_range(0, 2) - 1;
            if ($urandom_range(0, 1)) edge_dist = -edge_dist;
            axis = $urandom_range(0, 2);
            if (axis == 0) dx = edge_dist;
            else if (axis == 1) dy = edge_dist;
            else dz = edge_dist;
         end else begin
            dx = longint'($urandom_range(0, 32'(2 * bound))) - bound;
            dy = longint'($urandom_range(0, 32'(2 * bound))) - bound;
            dz = longint'($urandom_range(0, 32'(2 * bound))) - bound;
         end
         x = POS_W'(longint'(sb.anchor_x) + dx);
         y = POS_W'(longint'(sb.anchor_y) + dy);
         z = POS_W'(longint'(sb.anchor_z) + dz);
      end
   endtask

   task automatic run_random_phase(input int count);
      logic signed [POS_W-1:0]    x, y, z;
      logic [pvg_pkg::TIME_W-1:0] t;
      for (int i = 0; i < count; i++) begin
         make_track_pose(x, y, z, t);
         send_pose(x, y, z, t);
      end
      req_valid <= 1'b0;
      drain_results();
   endtask

   initial begin : stimulus
      logic [pvg_pkg::TIME_W-1:0] td;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: speed 5, min jump 50000, timeout 500000
      td = 32'hFFFF_FF00;
      send_pose(POS_MIN, POS_MAX, '0, td);                   // no reference yet
      send_pose(POS_MAX, POS_MIN, POS_MAX, td);              // zero elapsed time
      send_pose(POS_MIN, POS_MAX, POS_MIN, 32'h0000_0010);   // wrapped time, far jump
      send_pose(POS_W'(POS_MAX - 50000), POS_MIN, POS_MAX, 32'h20);   // jump equals min jump
      send_pose(POS_W'(POS_MAX - 100001), POS_MIN, POS_MAX, 32'h21);  // one past min jump
      td = 32'h20 + 20000;
      send_pose(POS_W'(POS_MAX - 50000), POS_W'(POS_MIN + 100000), POS_MAX,
                td);                                         // at speed limit
      send_pose(POS_W'(POS_MAX - 50000), POS_W'(POS_MIN + 200001), POS_MAX,
                td + 20000);                                 // just above it
      send_pose('0, '0, '0, td + 499999);                    // last tick inside timeout
      send_pose('0, '0, '0, td + 500000);                    // timeout reached
      td = td + 500000;
      send_pose('1, '1, '1, td - 5);                         // back in time
      send_pose('0, '0, '0, 32'hFFFF_FFFF);
      send_pose('0, '0, '0, 32'h0000_0000);
      send_pose(28'sh555_5555, 28'sh2AA_AAAA, 28'sh555_5555, 32'hAAAA_AAAA);
      send_pose(28'sh2AA_AAAA, 28'sh555_5555, 28'sh2AA_AAAA, 32'h5555_5555);
      run_random_phase(PHASE_ITEMS);

      // top speed and timeout, zero min jump; the receiver holds off while items keep coming
      write_settings(24'd255, 24'd0, 24'hFF_FFFF);
      hold_off_request = 1'b1;
      run_random_phase(PHASE_ITEMS);

      write_settings(24'd0, 24'hFF_FFFF, 24'd1);
      run_random_phase(PHASE_ITEMS);

      // zero timeout lets everything through
      write_settings(24'd0, 24'd0, 24'd0);
      run_random_phase(PHASE_ITEMS / 2);
      run_random_phase(PHASE_ITEMS / 2);

      // zero speed: only short jumps pass inside the timeout
      write_settings(24'd0, 24'd1000, 24'hFF_FFFF);
      run_random_phase(PHASE_ITEMS);

      write_settings(pvg_pkg::CSR_DATA_W'($urandom_range(1, 255)),
                     pvg_pkg::CSR_DATA_W'($urandom_range(0, 24'hFF_FFFF)),
                     pvg_pkg::CSR_DATA_W'($urandom_range(1, 24'hFF_FFFF)));
      run_random_phase(PHASE_ITEMS);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_count() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: pose_velocity_gate_unit.f
+incdir+rtl/core
rtl/core/pvg_pkg.sv
rtl/core/pvg_csr.sv
rtl/core/pvg_dp.sv
rtl/core/pvg_ctrl.sv
rtl/core/pose_velocity_gate_unit.sv
verif/pose_velocity_gate_unit_tb.sv
